FILE: design/dsbf_pkg.sv
// Shared types and constants of the decimal string to BCD float parser.
`default_nettype none

package dsbf_pkg;

    typedef enum logic [1:0] {
        EXP_NONE = 2'd0,
        EXP_POS  = 2'd1,
        EXP_NEG  = 2'd2
    } exp_mode_t;

    localparam logic [7:0]  CHAR_MINUS = 8'h2D;
    localparam logic [7:0]  CHAR_POINT = 8'h2E;
    localparam logic [7:0]  CHAR_EXP   = 8'h45;
    localparam logic [7:0]  CHAR_ZERO  = 8'h30;
    localparam logic [7:0]  CHAR_NINE  = 8'h39;

    localparam logic [14:0] EXP_LIMIT  = 15'd32767;
    localparam logic signed [8:0] POS_NONE = -9'sd1;

    typedef struct packed {
        logic                sign_flag;
        exp_mode_t           exp_mode;
        logic [14:0]         exp_accum;
        logic [7:0]          char_pos;
        logic signed [8:0]   point_pos;
        logic signed [8:0]   lead_pos;
        logic [4:0]          stored_digits;
        logic [63:0]         digit_store;
    } dsbf_state_t;

    localparam dsbf_state_t STATE_RESET = '{
        sign_flag:     1'b0,
        exp_mode:      EXP_NONE,
        exp_accum:     15'd0,
        char_pos:      8'd0,
        point_pos:     POS_NONE,
        lead_pos:      POS_NONE,
        stored_digits: 5'd0,
        digit_store:   64'd0
    };

endpackage

`default_nettype wire

FILE: design/dsbf_step.sv
// Parser state update for one character of the numeral.
`default_nettype none

module dsbf_step #(
    parameter int DIGITS    = 16,
    parameter int MAX_CHARS = 255
) (
    input  dsbf_pkg::dsbf_state_t state,
    input  logic [7:0]            character,
    output dsbf_pkg::dsbf_state_t state_next
);

    localparam logic [4:0] DIGIT_SLOTS = 5'(DIGITS);
    localparam logic [7:0] POS_LIMIT   = 8'(MAX_CHARS);

    logic [3:0]  digit;
    logic [5:0]  shift;
    logic [18:0] exp_prod;
    logic        put;

    always_comb
    begin
        state_next = state;
        digit      = character[3:0];
        shift      = 6'd60 - {state.stored_digits[3:0], 2'b00};
        exp_prod   = {1'b0, state.exp_accum, 3'b000} + {3'b000, state.exp_accum, 1'b0}
                     + {15'd0, digit};
        put        = 1'b0;

        if (state.stored_digits < DIGIT_SLOTS && state.char_pos < POS_LIMIT)
        begin
            state_next.char_pos = state.char_pos + 8'd1;
            if (character == dsbf_pkg::CHAR_MINUS)
            begin
                if (state.exp_mode != dsbf_pkg::EXP_NONE)
                    state_next.exp_mode = dsbf_pkg::EXP_NEG;
                else
                    state_next.sign_flag = 1'b1;
            end
            else if (character == dsbf_pkg::CHAR_POINT)
            begin
                if (state.point_pos == dsbf_pkg::POS_NONE)
                    state_next.point_pos = $signed({1'b0, state.char_pos});
            end
            else if (character == dsbf_pkg::CHAR_EXP)
            begin
                state_next.exp_mode = dsbf_pkg::EXP_POS;
            end
            else if (character >= dsbf_pkg::CHAR_ZERO && character <= dsbf_pkg::CHAR_NINE)
            begin
                if (state.exp_mode != dsbf_pkg::EXP_NONE)
                begin
                    if (exp_prod > {4'd0, dsbf_pkg::EXP_LIMIT})
                        state_next.exp_accum = dsbf_pkg::EXP_LIMIT;
                    else
                        state_next.exp_accum = exp_prod[14:0];
                end
                else if (state.lead_pos == dsbf_pkg::POS_NONE)
                begin
                    if (digit != 4'd0)
                    begin
                        state_next.lead_pos = $signed({1'b0, state.char_pos});
                        put = 1'b1;
                    end
                end
                else
                begin
                    put = 1'b1;
                end
            end
        end

        if (put)
        begin
            state_next.digit_store   = state.digit_store | ({60'd0, digit} << shift);
            state_next.stored_digits = state.stored_digits + 5'd1;
        end
    end

endmodule

`default_nettype wire

FILE: design/decimal_string_to_bcd_float.sv
// Top level of the streaming decimal numeral to BCD scientific number parser.
//
// Input channel: one ASCII character per transfer (in_valid, in_stall,
// character, final_char). A transfer with final_char set ends the numeral.
// Output channel: one result per numeral (out_valid, out_stall, negative,
// exponent, significand, digit_total), given after the final character.
// Throughput: one character per cycle, including across numerals, while the
// result register can take a result. The result of a final character passes
// through the input register, which holds it while the parse and exponent logic
// feed the result register.
// The result register lets the next characters enter while a result waits.
// A stalled result holds; once a second final character is parsed and the
// result register is still full, in_stall rises until the receiver takes it.
// Reset (rst_n low, asynchronous) empties both registers and returns the
// parser to its start state, ready for a new numeral.
`default_nettype none

module decimal_string_to_bcd_float #(
    parameter int DIGITS    = 16,
    parameter int MAX_CHARS = 255
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [7:0]         character,
    input  logic               final_char,
    output logic               out_valid,
    input  logic               out_stall,
    output logic               negative,
    output logic signed [15:0] exponent,
    output logic [63:0]        significand,
    output logic [4:0]         digit_total
);

    logic                  in_valid_reg;
    logic [7:0]            char_reg;
    logic                  final_reg;
    dsbf_pkg::dsbf_state_t state_reg;
    dsbf_pkg::dsbf_state_t step_next;

    logic                  out_valid_reg;
    logic                  negative_reg;
    logic signed [15:0]    exponent_reg;
    logic [63:0]           significand_reg;
    logic [4:0]            digit_total_reg;

    logic                  out_free;
    logic                  advance;
    logic                  load;

    logic signed [9:0]     pos_p;
    logic signed [9:0]     pos_l;
    logic signed [9:0]     base;
    logic signed [16:0]    exp_sum;
    logic signed [15:0]    exponent_next;

    dsbf_step #(
        .DIGITS    (DIGITS),
        .MAX_CHARS (MAX_CHARS)
    ) u_step (
        .state      (state_reg),
        .character  (char_reg),
        .state_next (step_next)
    );

    assign out_free = !out_valid_reg || !out_stall;
    assign advance  = in_valid_reg && (!final_reg || out_free);
    assign in_stall = in_valid_reg && !advance;
    assign load     = in_valid && !in_stall;

    always_comb
    begin
        pos_p = {step_next.point_pos[8], step_next.point_pos};
        pos_l = {step_next.lead_pos[8], step_next.lead_pos};
        if (step_next.sign_flag)
        begin
            if (pos_p != -10'sd1)
                pos_p = pos_p - 10'sd1;
            if (pos_l != -10'sd1)
                pos_l = pos_l - 10'sd1;
        end

        if (pos_p == -10'sd1)
            base = $signed({5'd0, step_next.stored_digits}) - 10'sd1;
        else if (pos_p > pos_l)
            base = pos_p - pos_l - 10'sd1;
        else
            base = pos_p - pos_l;

        exp_sum = {{7{base[9]}}, base};
        case (step_next.exp_mode)
            dsbf_pkg::EXP_POS: exp_sum = exp_sum + $signed({2'b00, step_next.exp_accum});
            dsbf_pkg::EXP_NEG: exp_sum = exp_sum - $signed({2'b00, step_next.exp_accum});
            default:           exp_sum = exp_sum;
        endcase

        if (exp_sum > 17'sd32767)
            exponent_next = 16'sd32767;
        else if (exp_sum < -17'sd32767)
            exponent_next = -16'sd32767;
        else
            exponent_next = exp_sum[15:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (load)
        begin
            in_valid_reg <= 1'b1;
        end
        else if (advance)
        begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            char_reg  <= character;
            final_reg <= final_char;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= dsbf_pkg::STATE_RESET;
        end
        else if (advance)
        begin
            state_reg <= final_reg ? dsbf_pkg::STATE_RESET : step_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance && final_reg)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && final_reg)
        begin
            negative_reg    <= (step_next.stored_digits != 5'd0) && step_next.sign_flag;
            exponent_reg    <= exponent_next;
            significand_reg <= step_next.digit_store;
            digit_total_reg <= step_next.stored_digits;
        end
    end

    assign out_valid   = out_valid_reg;
    assign negative    = negative_reg;
    assign exponent    = exponent_reg;
    assign significand = significand_reg;
    assign digit_total = digit_total_reg;

endmodule

`default_nettype wire

FILE: design/dsbf_check.sv
// Port-level checks of the parser, bound to the top level.
`default_nettype none

module dsbf_check #(
    parameter int DIGITS = 16
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               out_valid,
    input  logic               out_stall,
    input  logic               negative,
    input  logic signed [15:0] exponent,
    input  logic [63:0]        significand,
    input  logic [4:0]         digit_total
);

    localparam logic [4:0] DIGIT_SLOTS = 5'(DIGITS);

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid)
        else $error("result dropped while stalled");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && digit_total == 5'd0 |-> !negative && significand == 64'd0)
        else $error("zero result with sign or digits");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> digit_total <= DIGIT_SLOTS)
        else $error("digit count beyond slots");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> exponent != 16'sh8000)
        else $error("exponent outside saturation range");

endmodule

bind decimal_string_to_bcd_float dsbf_check #(.DIGITS(DIGITS)) u_dsbf_check (
    .clk         (clk),
    .rst_n       (rst_n),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .negative    (negative),
    .exponent    (exponent),
    .significand (significand),
    .digit_total (digit_total)
);

`default_nettype wire

FILE: tb/sv/decimal_string_to_bcd_float_tb.sv
`timescale 1ns / 100ps
// Self-checking testbench of the decimal string to BCD float parser, random traffic and stalls.
module decimal_string_to_bcd_float_tb;

    localparam int DIGIT_SLOTS  = 16;
    localparam int CHAR_LIMIT   = 255;
    localparam int HOLD_CYCLES  = 400;
    localparam int STALL_LIMIT  = 3000;
    localparam int DRAIN_CYCLES = 10;

    typedef struct packed {
        logic [7:0] code;
        logic       last;
    } char_item_t;

    typedef struct packed {
        logic        negative;
        logic [15:0] exponent;
        logic [63:0] significand;
        logic [4:0]  digit_total;
    } bcd_number_t;

    logic               clk        = 1'b0;
    logic               rst_n      = 1'b0;
    logic               in_valid   = 1'b0;
    logic               in_stall;
    logic [7:0]         character  = 8'd0;
    logic               final_char = 1'b0;
    logic               out_valid;
    logic               out_stall  = 1'b0;
    logic               negative;
    logic signed [15:0] exponent;
    logic [63:0]        significand;
    logic [4:0]         digit_total;

    char_item_t  char_q[$];
    bcd_number_t number_expect_q[$];
    logic [7:0]  numeral_buf[$];
    char_item_t  next_char;

    int   send_idle_pct   = 0;
    int   recv_stall_pct  = 0;
    logic sender_hold     = 1'b0;
    logic choke_on        = 1'b0;
    int   choke_cnt       = 0;
    int   idle_cycles     = 0;
    int   chars_sent      = 0;
    int   numbers_checked = 0;
    int   mismatches      = 0;
    int   full_cnt        = 0;
    int   sat_cnt         = 0;

    logic                minus_seen;
    dsbf_pkg::exp_mode_t exp_sign_mode;
    int                  exp_value;
    int                  char_count;
    int                  point_at;
    int                  lead_at;
    int                  digit_count;
    logic [63:0]         bcd_acc;

    decimal_string_to_bcd_float #(
        .DIGITS    (DIGIT_SLOTS),
        .MAX_CHARS (CHAR_LIMIT)
    ) u_top (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .character   (character),
        .final_char  (final_char),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .negative    (negative),
        .exponent    (exponent),
        .significand (significand),
        .digit_total (digit_total)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    task automatic clear_parse();
        minus_seen    = 1'b0;
        exp_sign_mode = dsbf_pkg::EXP_NONE;
        exp_value     = 0;
        char_count    = 0;
        point_at      = -1;
        lead_at       = -1;
        digit_count   = 0;
        bcd_acc       = 64'd0;
    endtask

    task automatic store_digit(input int d);
        bcd_acc[63 - 4 * digit_count -: 4] = d[3:0];
        digit_count++;
    endtask

    task automatic parse_char(input logic [7:0] ch, input logic last);
        int          pos;
        int          d;
        int          p;
        int          l;
        int          e;
        int          lim;
        bcd_number_t num;
        pos = char_count;
        lim = int'(dsbf_pkg::EXP_LIMIT);
        if (digit_count < DIGIT_SLOTS && char_count < CHAR_LIMIT)
        begin
            char_count++;
            if (ch == dsbf_pkg::CHAR_MINUS)
            begin
                if (exp_sign_mode != dsbf_pkg::EXP_NONE)
                    exp_sign_mode = dsbf_pkg::EXP_NEG;
                else
                    minus_seen = 1'b1;
            end
            else if (ch == dsbf_pkg::CHAR_POINT)
            begin
                if (point_at == -1)
                    point_at = pos;
            end
            else if (ch == dsbf_pkg::CHAR_EXP)
                exp_sign_mode = dsbf_pkg::EXP_POS;
            else if (ch >= dsbf_pkg::CHAR_ZERO && ch <= dsbf_pkg::CHAR_NINE)
            begin
                d = int'(ch) - int'(dsbf_pkg::CHAR_ZERO);
                if (exp_sign_mode != dsbf_pkg::EXP_NONE)
                begin
                    exp_value = exp_value * 10 + d;
                    if (exp_value > lim)
                        exp_value = lim;
                end
                else if (lead_at == -1)
                begin
                    if (d > 0)
                    begin
                        lead_at = pos;
                        store_digit(d);
                    end
                end
                else
                    store_digit(d);
            end
        end
        if (last)
        begin
            p = point_at;
            l = lead_at;
            if (minus_seen)
            begin
                if (l != -1)
                    l--;
                if (p != -1)
                    p--;
            end
            if (p == -1)
                e = digit_count - 1;
            else if (p > l)
                e = p - l - 1;
            else
                e = p - l;
            if (exp_sign_mode == dsbf_pkg::EXP_NEG)
                e = e - exp_value;
            else if (exp_sign_mode == dsbf_pkg::EXP_POS)
                e = e + exp_value;
            if (e > lim || e < -lim)
                sat_cnt++;
            if (e > lim)
                e = lim;
            if (e < -lim)
                e = -lim;
            if (digit_count == DIGIT_SLOTS)
                full_cnt++;
            num.negative    = (digit_count == 0) ? 1'b0 : minus_seen;
            num.exponent    = e[15:0];
            num.significand = bcd_acc;
            num.digit_total = digit_count[4:0];
            number_expect_q.push_back(num);
            clear_parse();
        end
    endtask

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        mismatches++;
        $display("mismatch at result %0d: %s got %0h want %0h",
                 numbers_checked, what, got, want);
    endtask

    task automatic check_number();
        bcd_number_t want;
        numbers_checked++;
        if (number_expect_q.size() == 0)
            report_mismatch("unexpected result, significand", significand, 64'd0);
        else
        begin
            want = number_expect_q.pop_front();
            if (negative !== want.negative)
                report_mismatch("negative", 64'(negative), 64'(want.negative));
            if (exponent !== want.exponent)
                report_mismatch("exponent", 64'(exponent), 64'(want.exponent));
            if (significand !== want.significand)
                report_mismatch("significand", significand, want.significand);
            if (digit_total !== want.digit_total)
                report_mismatch("digit_total", 64'(digit_total), 64'(want.digit_total));
        end
    endtask

    task automatic flush_numeral();
        char_item_t item;
        int         i;
        for (i = 0; i < numeral_buf.size(); i++)
        begin
            item.code = numeral_buf[i];
            item.last = (i == numeral_buf.size() - 1);
            char_q.push_back(item);
        end
        numeral_buf.delete();
    endtask

    task automatic push_text(input string s);
        int i;
        for (i = 0; i < s.len(); i++)
            numeral_buf.push_back(8'(s[i]));
        flush_numeral();
    endtask

    function automatic logic [7:0] rand_digit();
        return 8'(int'(dsbf_pkg::CHAR_ZERO) + $urandom_range(9));
    endfunction

    task automatic add_numeral();
        int kind;
        int nzero;
        int ndig;
        int npoint;
        int nexp;
        int n;
        int i;
        kind = $urandom_range(99);
        if (kind < 70)
        begin
            if ($urandom_range(1) == 1)
                numeral_buf.push_back(dsbf_pkg::CHAR_MINUS);
            nzero  = $urandom_range(3);
            ndig   = ($urandom_range(7) == 0) ? $urandom_range(22, 16) : $urandom_range(8);
            n      = nzero + ndig;
            npoint = ($urandom_range(2) == 0) ? -1 : $urandom_range(n);
            for (i = 0; i <= n; i++)
            begin
                if (i == npoint)
                    numeral_buf.push_back(dsbf_pkg::CHAR_POINT);
                if (i < nzero)
                    numeral_buf.push_back(dsbf_pkg::CHAR_ZERO);
                else if (i < n)
                    numeral_buf.push_back(rand_digit());
            end
            if ($urandom_range(9) < 4)
            begin
                numeral_buf.push_back(dsbf_pkg::CHAR_EXP);
                if ($urandom_range(1) == 1)
                    numeral_buf.push_back(dsbf_pkg::CHAR_MINUS);
                nexp = ($urandom_range(9) == 0) ? $urandom_range(7, 5) : $urandom_range(4);
                for (i = 0; i < nexp; i++)
                    numeral_buf.push_back(rand_digit());
            end
        end
        else if (kind < 88)
        begin
            n = $urandom_range(16, 1);
            for (i = 0; i < n; i++)
            begin
                case ($urandom_range(5))
                    0:       numeral_buf.push_back(dsbf_pkg::CHAR_MINUS);
                    1:       numeral_buf.push_back(dsbf_pkg::CHAR_POINT);
                    2:       numeral_buf.push_back(dsbf_pkg::CHAR_EXP);
                    3, 4:    numeral_buf.push_back(rand_digit());
                    default: numeral_buf.push_back(8'($urandom_range(255)));
                endcase
            end
        end
        else
        begin
            n = $urandom_range(6, 1);
            for (i = 0; i < n; i++)
                numeral_buf.push_back(8'($urandom_range(255)));
        end
        if (numeral_buf.size() == 0)
            numeral_buf.push_back(dsbf_pkg::CHAR_ZERO);
        flush_numeral();
    endtask

    // Run past the character limit without filling the digit slots.
    task automatic add_overlong();
        int i;
        numeral_buf.push_back(dsbf_pkg::CHAR_MINUS);
        for (i = 0; i < 252; i++)
        begin
            case ($urandom_range(3))
                0, 1:    numeral_buf.push_back(dsbf_pkg::CHAR_ZERO);
                2:       numeral_buf.push_back(dsbf_pkg::CHAR_POINT);
                default: numeral_buf.push_back(8'h20);
            endcase
        end
        for (i = 0; i < 12; i++)
            numeral_buf.push_back(8'(int'(dsbf_pkg::CHAR_ZERO) + $urandom_range(9, 1)));
        flush_numeral();
    endtask

    task automatic wait_sent();
        while (char_q.size() != 0 || in_valid)
            @(negedge clk);
    endtask

    task automatic run_phase(input int send_pct, input int recv_pct, input int n_chars);
        @(negedge clk);
        send_idle_pct  = send_pct;
        recv_stall_pct = recv_pct;
        while (char_q.size() < n_chars)
            add_numeral();
        wait_sent();
    endtask

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && !in_stall)
            begin
                parse_char(character, final_char);
                chars_sent++;
            end
            if (!in_valid || !in_stall)
            begin
                if (char_q.size() != 0 && !sender_hold &&
                    $urandom_range(99) >= send_idle_pct)
                begin
                    next_char  = char_q.pop_front();
                    in_valid   <= 1'b1;
                    character  <= next_char.code;
                    final_char <= next_char.last;
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_valid && !out_stall)
                check_number();
            if (!choke_on)
                choke_cnt <= 0;
            else if (choke_cnt < HOLD_CYCLES)
                choke_cnt <= choke_cnt + 1;
            out_stall <= (choke_on && choke_cnt < HOLD_CYCLES) ||
                         ($urandom_range(99) < recv_stall_pct);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
                idle_cycles <= 0;
            else if (idle_cycles >= STALL_LIMIT)
            begin
                $display("decimal_string_to_bcd_float_tb failed");
                $finish;
            end
            else
                idle_cycles <= idle_cycles + 1;
        end
    end

    initial
    begin
        clear_parse();
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        push_text("-0.0120E-3");
        numeral_buf.push_back(8'hFF);
        numeral_buf.push_back(8'h00);
        numeral_buf.push_back(dsbf_pkg::CHAR_POINT);
        numeral_buf.push_back(dsbf_pkg::CHAR_POINT);
        numeral_buf.push_back(8'h35);
        flush_numeral();
        push_text("1E2E3");
        push_text("0");
        push_text("5E99999");
        wait_sent();

        @(negedge clk);
        add_overlong();
        run_phase(0, 0, 300);
        run_phase(70, 0, 250);
        run_phase(0, 70, 250);
        @(negedge clk);
        add_overlong();
        run_phase(9, 9, 250);

        // hold the output long enough for the input side to back up
        @(negedge clk);
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        choke_on       = 1'b1;
        while (char_q.size() < 80)
            add_numeral();
        wait_sent();
        choke_on = 1'b0;

        @(negedge clk);
        send_idle_pct  = 9;
        recv_stall_pct = 9;
        while (char_q.size() < 300)
            add_numeral();
        while (char_q.size() > 150)
            @(negedge clk);
        sender_hold = 1'b1;
        while (number_expect_q.size() != 0 || in_valid)
            @(negedge clk);
        sender_hold = 1'b0;
        wait_sent();

        while (number_expect_q.size() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);

        $display("%0d characters sent, %0d numbers checked, %0d with every digit slot used",
                 chars_sent, numbers_checked, full_cnt);
        $display("%0d saturated exponents; idle, stall, hold and pause phases; %0d mismatches",
                 sat_cnt, mismatches);
        if (mismatches == 0)
            $display("decimal_string_to_bcd_float_tb passed");
        else
            $display("decimal_string_to_bcd_float_tb failed");
        $finish;
    end

endmodule

FILE: decimal_string_to_bcd_float.f
design/dsbf_pkg.sv
design/dsbf_step.sv
design/decimal_string_to_bcd_float.sv
design/dsbf_check.sv
tb/sv/decimal_string_to_bcd_float_tb.sv
